### rtl/core/lcus_pkg.sv
`default_nettype none
package lcus_pkg;

    localparam int STEP_COUNT = 4;
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEP_COUNT - 1);

    localparam logic [8:0] RETRY_PERIOD = 9'd30;
    localparam logic [8:0] STEP0_WAIT = 9'd120;
    localparam logic [8:0] STEP0_LONG = 9'd300;
    localparam logic [15:0] NOT_READY_HOLD = 16'd50;
    localparam logic [16:0] RESTART_MARGIN = 17'd10;
    localparam logic [6:0] HEARTBEAT_MOD = 7'd99;
    localparam logic [4:0] SIM_MOD = 5'd20;
    localparam logic [15:0] CONFIG_MOD = 16'd36000;
    localparam logic [11:0] TIME_MOD = 12'd3010;

    localparam logic [1:0] MODEM_NOT_READY = 2'd1;
    localparam logic [1:0] MODEM_FRESH = 2'd2;

    localparam logic [1:0] REG_RECORD_INTERVAL = 2'd0;
    localparam logic [1:0] REG_POSITION_LIMIT = 2'd1;
    localparam logic [1:0] REG_FORCED_COUNT = 2'd2;
    localparam logic [1:0] REG_SILENCE_TIMEOUT = 2'd3;

    typedef struct packed {
        logic ack_seen;
        logic reply_seen;
        logic [1:0] modem_ready;
        logic alarm_pending;
        logic [1:0] alarm_level;
        logic signed [31:0] position_delta;
        logic sim_idle;
    } t_item;

    typedef struct packed {
        logic send_heartbeat;
        logic request_time;
        logic send_power_on;
        logic send_config;
        logic send_alarm;
        logic send_record;
        logic send_sim;
        logic modem_restart;
        logic online;
        logic connected;
    } t_result;

    typedef struct packed {
        logic start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic [31:0] quot;
        logic [15:0] rem;
    } t_div_rsp;

endpackage
`default_nettype wire

### rtl/core/lcus_front.sv
`default_nettype none
module lcus_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    output logic                o_full,
    input  wire lcus_pkg::t_item i_item,
    input  wire logic           i_take,
    output logic                o_valid,
    output lcus_pkg::t_item     o_item
);
    lcus_pkg::t_item r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_put, w_get;

    assign o_full = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item = r_mem[r_rp];
    assign w_put = i_push && !o_full;
    assign w_get = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_put) begin
                r_wp <= ~r_wp;
            end
            if (w_get) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_put} - {1'b0, w_get};
        end
    end
endmodule
`default_nettype wire

### rtl/core/lcus_div.sv
`default_nettype none
module lcus_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lcus_pkg::t_div_req i_req,
    output lcus_pkg::t_div_rsp     o_rsp
);
    logic r_busy;
    logic [5:0] r_cnt;
    logic [31:0] r_quot;
    logic [15:0] r_rem;
    logic [15:0] r_div;
    logic r_done;
    logic [16:0] w_trial;
    logic w_ge;

    // restoring division, one quotient bit per cycle
    assign w_trial = {r_rem, r_quot[31]};
    assign w_ge = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem <= 16'd0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[30:0], w_ge};
            r_rem <= w_ge ? 16'(w_trial - {1'b0, r_div}) : w_trial[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= 6'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem = r_rem;
endmodule
`default_nettype wire

### rtl/core/lcus_back.sv
`default_nettype none
module lcus_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_valid,
    input  wire lcus_pkg::t_item    i_item,
    output logic                    o_take,
    output lcus_pkg::t_div_req      o_div_req,
    input  wire lcus_pkg::t_div_rsp i_div_rsp,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output lcus_pkg::t_result       o_result
);
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_START  = 4'b0010,
        S_WAIT   = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [15:0] r_interval, r_limit, r_timeout;
    logic [7:0] r_forced;

    logic r_conn, n_conn;
    logic r_acked, n_acked;
    logic [lcus_pkg::STEP_W-1:0] r_step, n_step;
    logic [15:0] r_att, n_att;
    logic [8:0] r_p0, n_p0;
    logic [31:0] r_tick, n_tick;
    logic [15:0] r_sil, n_sil;
    logic [7:0] r_skip, n_skip;
    logic r_online, n_online;
    // residues of the tick count for the fixed schedules
    logic [6:0] r_m99, n_m99;
    logic [4:0] r_m20, n_m20;
    logic [15:0] r_m36k, n_m36k;
    logic [11:0] r_m3k, n_m3k;

    lcus_pkg::t_item r_item;
    logic [31:0] r_quot;
    logic [15:0] r_rem;
    logic r_out_valid;
    lcus_pkg::t_result r_out, n_out;

    logic w_commit;
    logic [15:0] w_att_inc;
    logic [8:0] w_period;
    logic [15:0] w_interval;

    logic sa, send_v, done, tick_en;
    logic [lcus_pkg::STEP_W-1:0] send_s;
    logic [lcus_pkg::STEP_W:0] nxt;
    logic [16:0] sil_lim;
    logic signed [33:0] dlt, lim;
    logic [7:0] skip_inc;

    assign w_att_inc = r_att + 16'd1;
    assign w_period = (r_step == '0) ? r_p0 : lcus_pkg::RETRY_PERIOD;
    assign w_interval = (r_interval == 16'd0) ? 16'd1 : r_interval;
    assign w_commit = (r_state == S_COMMIT) && (!r_out_valid || i_pop);
    assign o_take = (r_state == S_IDLE) && i_valid;

    always_comb begin
        o_div_req.start = (r_state == S_START);
        if (r_conn) begin
            o_div_req.dividend = r_tick;
            o_div_req.divisor = w_interval;
        end else begin
            o_div_req.dividend = {16'd0, w_att_inc};
            o_div_req.divisor = (w_period == 9'd0) ? 16'd1 : {7'd0, w_period};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_START;
            S_START:  n_state = S_WAIT;
            S_WAIT:   if (i_div_rsp.done) n_state = S_COMMIT;
            S_COMMIT: if (w_commit) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        sa = r_acked | r_item.ack_seen;
        n_conn = r_conn;
        n_acked = sa;
        n_step = r_step;
        n_att = r_att;
        n_p0 = r_p0;
        n_tick = r_tick;
        n_sil = r_item.reply_seen ? 16'd0 : r_sil;
        n_skip = r_skip;
        n_online = r_online;
        n_m99 = r_m99;
        n_m20 = r_m20;
        n_m36k = r_m36k;
        n_m3k = r_m3k;
        n_out = '0;
        send_v = 1'b0;
        send_s = '0;
        done = 1'b0;
        tick_en = 1'b0;
        nxt = {1'b0, r_step} + 1'b1;
        sil_lim = {1'b0, r_timeout} + lcus_pkg::RESTART_MARGIN;
        dlt = 34'(r_item.position_delta);
        lim = $signed({18'd0, r_limit});
        skip_inc = r_skip + 8'd1;

        if (!r_conn) begin
            n_att = w_att_inc;
            if (sa) begin
                n_acked = 1'b0;
                n_att = 16'd0;
                if (nxt >= (lcus_pkg::STEP_W + 1)'(lcus_pkg::STEP_COUNT)) begin
                    done = 1'b1;
                    n_step = '0;
                end else begin
                    n_step = nxt[lcus_pkg::STEP_W-1:0];
                    send_v = 1'b1;
                    send_s = nxt[lcus_pkg::STEP_W-1:0];
                end
            end else if (r_p0 == 9'd0) begin
                n_p0 = lcus_pkg::STEP0_WAIT;
            end else if (r_item.modem_ready == lcus_pkg::MODEM_FRESH
                         && r_p0 == lcus_pkg::STEP0_WAIT) begin
                send_v = 1'b1;
                send_s = '0;
                n_p0 = lcus_pkg::RETRY_PERIOD;
                n_att = 16'd0;
            end else if (r_item.modem_ready == lcus_pkg::MODEM_NOT_READY
                         && w_att_inc < lcus_pkg::NOT_READY_HOLD) begin
                n_att = w_att_inc;
            end else if (r_rem == 16'd0) begin
                send_v = 1'b1;
                send_s = r_step;
                if (r_step == lcus_pkg::LAST_STEP) begin
                    if (r_quot > 32'd2) begin
                        done = 1'b1;
                        n_step = '0;
                        n_acked = 1'b0;
                        send_v = 1'b0;
                        n_att = 16'd0;
                    end
                end else if (r_step == '0) begin
                    if (w_period == lcus_pkg::STEP0_WAIT) begin
                        n_p0 = lcus_pkg::RETRY_PERIOD;
                        n_att = 16'd0;
                    end else if (r_quot > 32'd10) begin
                        n_p0 = lcus_pkg::STEP0_LONG;
                        n_att = 16'd0;
                    end
                end else if (r_quot > 32'd2) begin
                    n_step = r_step + 1'b1;
                    send_s = r_step + 1'b1;
                    n_att = 16'd0;
                end
            end
            if (send_v) begin
                if (send_s == lcus_pkg::LAST_STEP) begin
                    n_out.send_config = 1'b1;
                    n_acked = 1'b1;
                end else if (send_s == 0) begin
                    n_out.send_heartbeat = 1'b1;
                end else if (send_s == 1) begin
                    n_out.request_time = 1'b1;
                end else if (send_s == 2) begin
                    n_out.send_power_on = 1'b1;
                end
            end
            if (done) begin
                n_conn = 1'b1;
            end
        end else begin
            if (n_sil != 16'hFFFF) begin
                n_sil = n_sil + 16'd1;
            end
            if (n_sil > r_timeout) begin
                n_online = 1'b0;
                if ({1'b0, n_sil} >= sil_lim || n_sil == 16'hFFFF) begin
                    n_out.modem_restart = 1'b1;
                    n_p0 = lcus_pkg::RETRY_PERIOD;
                    n_acked = 1'b0;
                    n_step = '0;
                    n_att = 16'd0;
                    n_tick = 32'd0;
                    n_m99 = '0;
                    n_m20 = '0;
                    n_m36k = '0;
                    n_m3k = '0;
                    n_sil = 16'd0;
                    n_conn = 1'b0;
                end
            end else begin
                n_online = 1'b1;
                tick_en = 1'b1;
                if (r_item.alarm_pending
                    && (r_item.alarm_level == 2'd1 || r_item.alarm_level == 2'd2)) begin
                    n_out.send_alarm = 1'b1;
                end else if (r_rem == 16'd0) begin
                    if (dlt > lim || dlt < -lim) begin
                        n_out.send_record = 1'b1;
                        n_skip = 8'd0;
                    end else if (skip_inc >= r_forced) begin
                        n_out.send_record = 1'b1;
                        n_skip = 8'd0;
                    end else begin
                        n_skip = skip_inc;
                    end
                end
                if (r_m99 == '0) begin
                    n_out.send_heartbeat = 1'b1;
                end else if (r_m20 == '0 && r_item.sim_idle) begin
                    n_out.send_sim = 1'b1;
                end
                if (r_m36k == '0) begin
                    n_out.send_config = 1'b1;
                end else if (r_m3k == '0) begin
                    n_out.request_time = 1'b1;
                end
            end
        end

        if (tick_en) begin
            n_tick = r_tick + 32'd1;
            if (r_tick == 32'hFFFF_FFFF) begin
                n_m99 = '0;
                n_m20 = '0;
                n_m36k = '0;
                n_m3k = '0;
            end else begin
                n_m99 = (r_m99 == lcus_pkg::HEARTBEAT_MOD - 7'd1) ? '0 : r_m99 + 7'd1;
                n_m20 = (r_m20 == lcus_pkg::SIM_MOD - 5'd1) ? '0 : r_m20 + 5'd1;
                n_m36k = (r_m36k == lcus_pkg::CONFIG_MOD - 16'd1) ? '0 : r_m36k + 16'd1;
                n_m3k = (r_m3k == lcus_pkg::TIME_MOD - 12'd1) ? '0 : r_m3k + 12'd1;
            end
        end

        n_out.online = n_online;
        n_out.connected = n_conn;
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_item <= i_item;
        end
        if (i_div_rsp.done) begin
            r_quot <= i_div_rsp.quot;
            r_rem <= i_div_rsp.rem;
        end
        if (w_commit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_interval <= 16'd20;
            r_limit <= 16'd80;
            r_forced <= 8'd15;
            r_timeout <= 16'd6200;
            r_conn <= 1'b0;
            r_acked <= 1'b0;
            r_step <= '0;
            r_att <= 16'd0;
            r_p0 <= 9'd0;
            r_tick <= 32'd0;
            r_sil <= 16'd0;
            r_skip <= 8'd0;
            r_online <= 1'b0;
            r_m99 <= '0;
            r_m20 <= '0;
            r_m36k <= '0;
            r_m3k <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lcus_pkg::REG_RECORD_INTERVAL: r_interval <= i_cfg_data;
                    lcus_pkg::REG_POSITION_LIMIT:  r_limit <= i_cfg_data;
                    lcus_pkg::REG_FORCED_COUNT:    r_forced <= i_cfg_data[7:0];
                    lcus_pkg::REG_SILENCE_TIMEOUT: r_timeout <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_commit) begin
                r_conn <= n_conn;
                r_acked <= n_acked;
                r_step <= n_step;
                r_att <= n_att;
                r_p0 <= n_p0;
                r_tick <= n_tick;
                r_sil <= n_sil;
                r_skip <= n_skip;
                r_online <= n_online;
                r_m99 <= n_m99;
                r_m20 <= n_m20;
                r_m36k <= n_m36k;
                r_m3k <= n_m3k;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty = !r_out_valid;
    assign o_result = r_out;
endmodule
`default_nettype wire

### rtl/core/link_connect_and_upload_scheduler_top.sv
// Link connect and upload scheduler.
// Input channel: one transaction per 100 ms tick, pushed with push while full
// is low. A two-entry input queue lets the next tick be taken while the
// current one is worked on or its result waits.
// Result channel: one transaction per tick, held on the o_ ports while empty is
// low and removed with pop. Send flags are one-tick pulses; online and
// connected give the link state after the tick.
// In the back end a tick is picked up from the queue in the idle state, the
// start state starts the shared 32-step restoring divider (tick count modulo
// the record interval, or attempt count by the current step's period), the
// wait state waits for the divider's registered done flag, and the commit
// state writes the result. The back end takes no new tick until it has
// committed the current one.
// If the receiver stalls, the finished result stays in the output register,
// the back end waits at commit, and the input queue fills and raises full.
// Configuration writes are taken at once on the write enable.
// Synchronous reset loads the register defaults and returns to disconnected
// state at connect step 0 with empty queues.
`default_nettype none
module link_connect_and_upload_scheduler_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_ack_seen,
    input  wire logic        i_reply_seen,
    input  wire logic [1:0]  i_modem_ready,
    input  wire logic        i_alarm_pending,
    input  wire logic [1:0]  i_alarm_level,
    input  wire logic signed [31:0] i_position_delta,
    input  wire logic        i_sim_idle,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_send_heartbeat,
    output logic             o_request_time,
    output logic             o_send_power_on,
    output logic             o_send_config,
    output logic             o_send_alarm,
    output logic             o_send_record,
    output logic             o_send_sim,
    output logic             o_modem_restart,
    output logic             o_online,
    output logic             o_connected
);
    lcus_pkg::t_item w_in, w_q;
    lcus_pkg::t_result w_res;
    lcus_pkg::t_div_req w_req;
    lcus_pkg::t_div_rsp w_rsp;
    logic w_valid, w_take;

    assign w_in.ack_seen = i_ack_seen;
    assign w_in.reply_seen = i_reply_seen;
    assign w_in.modem_ready = i_modem_ready;
    assign w_in.alarm_pending = i_alarm_pending;
    assign w_in.alarm_level = i_alarm_level;
    assign w_in.position_delta = i_position_delta;
    assign w_in.sim_idle = i_sim_idle;

    lcus_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_item(w_in), .i_take(w_take), .o_valid(w_valid), .o_item(w_q)
    );

    lcus_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp)
    );

    lcus_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(w_valid), .i_item(w_q), .o_take(w_take),
        .o_div_req(w_req), .i_div_rsp(w_rsp),
        .i_pop(pop), .o_empty(empty), .o_result(w_res)
    );

    assign o_send_heartbeat = w_res.send_heartbeat;
    assign o_request_time = w_res.request_time;
    assign o_send_power_on = w_res.send_power_on;
    assign o_send_config = w_res.send_config;
    assign o_send_alarm = w_res.send_alarm;
    assign o_send_record = w_res.send_record;
    assign o_send_sim = w_res.send_sim;
    assign o_modem_restart = w_res.modem_restart;
    assign o_online = w_res.online;
    assign o_connected = w_res.connected;

`ifndef SYNTHESIS
    a_restart_drops_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_modem_restart) |-> (!o_connected && !o_online))
        else $error("restart with link still up");
    a_online_needs_connect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_online) |-> o_connected)
        else $error("online while not connected");
    a_alarm_only_online: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_send_alarm || o_send_record || o_send_sim)) |-> o_online)
        else $error("upload while offline");
`endif
endmodule
`default_nettype wire
